### hdl/swvr_pkg.sv
// Shared constants, types and codes for the stack with value removal.
`timescale 1ns / 1ps
package swvr_pkg;

    localparam int DEPTH   = 16;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VALUE_W = 32;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [CMD_W-1:0]   t_cmd;
    typedef logic [STAT_W-1:0]  t_status;
    typedef logic [COUNT_W-1:0] t_count;

    // command codes
    localparam t_cmd CMD_PUSH   = 2'd0;
    localparam t_cmd CMD_POP    = 2'd1;
    localparam t_cmd CMD_REMOVE = 2'd2;

    // status codes
    localparam t_status ST_DONE     = 2'd0;
    localparam t_status ST_EMPTY    = 2'd1;
    localparam t_status ST_NOTFOUND = 2'd2;
    localparam t_status ST_FULL     = 2'd3;

endpackage

### hdl/swvr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module swvr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/stack_with_value_removal.sv
// Top level: bounded LIFO stack with push, pop and remove-first-match-from-top.
// Push, pop, unused codes and a remove on an empty stack are answered in idle.
// Remove: entries are read and compared from the top downward; after a match
//   each entry above it is read and then written one slot down to close the
//   gap, a split set by the single read port of the entry RAM.
// One request at a time; the next is taken in idle with a free result slot.
// Reset (synchronous, active low) empties the stack and the result register;
//   the entry RAM is not cleared, only entries below the fill count are read.
`timescale 1ns / 1ps
module stack_with_value_removal (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_cmd,
    input  logic signed [31:0]        i_value,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [1:0]                o_status,
    output logic [4:0]                o_count
);

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN_RD  = 3'd1;  // issue read of candidate entry
    localparam logic [2:0] S_SCAN_CMP = 3'd2;  // compare read data to key
    localparam logic [2:0] S_SHIFT_RD = 3'd3;  // read entry above the hole
    localparam logic [2:0] S_SHIFT_WR = 3'd4;  // write it one slot down

    logic [2:0]              r_state, n_state;
    swvr_pkg::t_cnt          r_fill, n_fill;
    swvr_pkg::t_addr         r_ptr, n_ptr;
    swvr_pkg::t_value        r_value, n_value;

    logic                    r_out_valid, n_out_valid;
    swvr_pkg::t_status       r_status, n_status;
    swvr_pkg::t_count        r_count, n_count;

    // RAM port signals
    logic                    wr_en;
    swvr_pkg::t_addr         wr_addr;
    swvr_pkg::t_value        wr_data;
    swvr_pkg::t_addr         rd_addr;
    swvr_pkg::t_value        rd_data;

    logic                    slot_free;
    logic                    in_accept;
    logic                    ld;
    swvr_pkg::t_status       ld_status;
    logic                    is_full;
    logic                    is_empty;

    swvr_ram #(
        .WIDTH (swvr_pkg::VALUE_W),
        .DEPTH (swvr_pkg::DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // The result register is free at this edge if empty or being drained.
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && slot_free);
    assign in_accept  = i_in_valid && !o_in_stall;

    assign is_full  = (r_fill == swvr_pkg::t_cnt'(swvr_pkg::DEPTH));
    assign is_empty = (r_fill == '0);

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_ptr     = r_ptr;
        n_value   = r_value;
        wr_en     = 1'b0;
        wr_addr   = r_ptr;
        wr_data   = rd_data;
        rd_addr   = r_ptr;
        ld        = 1'b0;
        ld_status = swvr_pkg::ST_DONE;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    case (i_cmd)
                        swvr_pkg::CMD_PUSH: begin
                            ld = 1'b1;
                            if (is_full) begin
                                ld_status = swvr_pkg::ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = swvr_pkg::t_addr'(r_fill);
                                wr_data = swvr_pkg::t_value'(i_value);
                                n_fill  = r_fill + 1'b1;
                            end
                        end
                        swvr_pkg::CMD_POP: begin
                            ld = 1'b1;
                            if (is_empty) begin
                                ld_status = swvr_pkg::ST_EMPTY;
                            end else begin
                                n_fill = r_fill - 1'b1;
                            end
                        end
                        swvr_pkg::CMD_REMOVE: begin
                            if (is_empty) begin
                                ld        = 1'b1;
                                ld_status = swvr_pkg::ST_EMPTY;
                            end else begin
                                // search starts at the top entry
                                n_ptr   = swvr_pkg::t_addr'(r_fill - 1'b1);
                                n_value = swvr_pkg::t_value'(i_value);
                                n_state = S_SCAN_RD;
                            end
                        end
                        default: begin
                            // unused code: no change, report current fill
                            ld = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                rd_addr = r_ptr;
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (rd_data == r_value) begin
                    n_state = S_SHIFT_RD;
                end else if (r_ptr == '0) begin
                    // bottom reached without a match
                    ld        = 1'b1;
                    ld_status = swvr_pkg::ST_NOTFOUND;
                    n_state   = S_IDLE;
                end else begin
                    n_ptr   = r_ptr - 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                if (swvr_pkg::t_cnt'(r_ptr) + 1'b1 >= r_fill) begin
                    // hole is at the top: drop it
                    n_fill  = r_fill - 1'b1;
                    ld      = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    rd_addr = r_ptr + 1'b1;
                    n_state = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_ptr;
                wr_data = rd_data;
                n_ptr   = r_ptr + 1'b1;
                n_state = S_SHIFT_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // result register
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_count     = r_count;
        if (ld) begin
            n_out_valid = 1'b1;
            n_status    = ld_status;
            n_count     = swvr_pkg::t_count'(n_fill);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_value  <= n_value;
        r_status <= n_status;
        r_count  <= n_count;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_count     = r_count;

endmodule

### verif/testbench.sv
// Self-checking testbench for the stack with push, pop and remove-by-value.
`timescale 1ns / 1ps
module testbench;

    // Code 3 has no operation behind it; the block must leave the stack alone.
    localparam swvr_pkg::t_cmd CMD_NOP = 2'd3;

    localparam int TARGET_REQS = 1850;     // real requests (code 3 not counted)
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 4 * swvr_pkg::DEPTH + 40;

    // ---------------------------------------------------------------- types
    typedef struct {
        swvr_pkg::t_value ent [swvr_pkg::DEPTH];
        int               fill;
    } t_stack_img;

    typedef struct packed {
        swvr_pkg::t_status status;
        swvr_pkg::t_count  count;
    } t_stack_reply;

    typedef struct {
        swvr_pkg::t_cmd   cmd;
        swvr_pkg::t_value value;
        int               gap;    // idle cycles before the request is offered
        bit               drain;  // hold the request until no reply is pending
    } t_stack_req;

    // ---------------------------------------------------------------- DUT
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    logic [1:0]          i_cmd       = swvr_pkg::CMD_PUSH;
    logic signed [31:0]  i_value     = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [1:0]          o_status;
    logic [4:0]          o_count;

    stack_with_value_removal dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_count     (o_count)
    );

    // 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 0;
    end

    // ---------------------------------------------------------------- state
    t_stack_req   pending_reqs[$];     // requests not yet offered
    t_stack_reply replies_due[$];      // predicted replies, oldest first
    t_stack_img   stack_now;           // predicted stack, advanced on accept
    t_stack_img   stack_gen;           // stack as the generator expects it
    int           errors      = 0;
    int           cycles      = 0;
    int           real_reqs   = 0;
    bit           req_taken   = 1'b0;  // request accepted at the last rising edge
    bit           have_cur    = 1'b0;
    t_stack_req   cur;
    int           wait_left   = 0;
    bit           seq_calm    = 1'b0;  // current sequence runs without gaps
    bit           drain_next  = 1'b0;
    int           stall_left  = 0;
    int           calm_left   = 0;

    // ---------------------------------------------------------------- predictor
    // Applies one request to a stack image and returns the reply it produces.
    // Remove scans from the top down and closes the gap over the first match.
    function automatic t_stack_reply apply_request(inout t_stack_img s,
                                                   input swvr_pkg::t_cmd c,
                                                   input swvr_pkg::t_value v);
        t_stack_reply r;
        int pos;
        int j;
        bit hit;
        r.status = swvr_pkg::ST_DONE;
        hit      = 1'b0;
        case (c)
            swvr_pkg::CMD_PUSH: begin
                if (s.fill >= swvr_pkg::DEPTH) begin
                    r.status = swvr_pkg::ST_FULL;
                end else begin
                    s.ent[s.fill] = v;
                    s.fill++;
                end
            end
            swvr_pkg::CMD_POP: begin
                if (s.fill == 0) r.status = swvr_pkg::ST_EMPTY;
                else s.fill--;
            end
            swvr_pkg::CMD_REMOVE: begin
                if (s.fill == 0) begin
                    r.status = swvr_pkg::ST_EMPTY;
                end else begin
                    for (pos = s.fill - 1; pos >= 0 && !hit; pos--) begin
                        if (s.ent[pos] == v) begin
                            hit = 1'b1;
                            for (j = pos; j + 1 < s.fill; j++) s.ent[j] = s.ent[j + 1];
                        end
                    end
                    if (hit) s.fill--;
                    else r.status = swvr_pkg::ST_NOTFOUND;
                end
            end
            default: ;
        endcase
        r.count = swvr_pkg::t_count'(s.fill);
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch @%0d: %s", cycles, what);
    endtask

    // ---------------------------------------------------------------- stimulus helpers
    // Mostly short gaps, some medium, a few long.
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Half the values come from a small pool so that duplicates and matches occur.
    function automatic swvr_pkg::t_value pick_value();
        swvr_pkg::t_value pool [8];
        pool = '{32'h0, 32'h1, 32'h2, 32'h3, 32'hFFFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h5555_5555};
        if ($urandom_range(0, 1) == 0) return pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    task automatic add_req(input swvr_pkg::t_cmd c, input swvr_pkg::t_value v);
        t_stack_req   rq;
        t_stack_reply unused;
        rq.cmd    = c;
        rq.value  = v;
        rq.gap    = seq_calm ? 0 : rand_gap();
        rq.drain  = drain_next;
        drain_next = 1'b0;
        unused = apply_request(stack_gen, c, v);
        pending_reqs.push_back(rq);
        if (c != CMD_NOP) real_reqs++;
    endtask

    task automatic add_fill_seq();
        while (stack_gen.fill < swvr_pkg::DEPTH) add_req(swvr_pkg::CMD_PUSH, pick_value());
        repeat ($urandom_range(1, 3)) add_req(swvr_pkg::CMD_PUSH, pick_value()); // refused
        add_req(swvr_pkg::CMD_REMOVE, stack_gen.ent[0]);                        // bottom entry
        add_req(swvr_pkg::CMD_REMOVE, stack_gen.ent[stack_gen.fill - 1]);      // top entry
    endtask

    // Remove a value that is held, else something likely absent.
    task automatic add_remove_seq(input int n);
        repeat (n) begin
            if (stack_gen.fill > 0 && $urandom_range(0, 9) < 7)
                add_req(swvr_pkg::CMD_REMOVE,
                        stack_gen.ent[$urandom_range(0, stack_gen.fill - 1)]);
            else
                add_req(swvr_pkg::CMD_REMOVE, pick_value());
        end
    endtask

    // ---------------------------------------------------------------- monitor / scoreboard
    always @(posedge i_clk) begin
        t_stack_reply got;
        t_stack_reply want;
        cycles++;
        req_taken = 1'b0;
        if (i_rst_n) begin
            // results: compare against the oldest prediction
            if (o_out_valid && !i_out_stall) begin
                got.status = o_status;
                got.count  = o_count;
                if (replies_due.size() == 0) begin
                    report_mismatch($sformatf("reply with none pending (status %0d count %0d)",
                                              got.status, got.count));
                end else begin
                    want = replies_due.pop_front();
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                                  got.status, want.status));
                    if (got.count !== want.count)
                        report_mismatch($sformatf("count %0d, predicted %0d",
                                                  got.count, want.count));
                end
            end
            // requests: advance the predicted stack on each accept
            if (i_in_valid && !o_in_stall) begin
                req_taken = 1'b1;
                replies_due.push_back(apply_request(stack_now, i_cmd, i_value));
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            report_mismatch($sformatf("timeout, %0d replies pending", replies_due.size()));
            $display("testbench: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------- request driver
    // Runs on the falling edge; the payload only moves once the request is gone.
    always @(negedge i_clk) begin
        logic nv;
        nv = i_in_valid;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else begin
            if (i_in_valid && req_taken) begin
                nv       = 1'b0;
                have_cur = 1'b0;
            end
            if (!have_cur && pending_reqs.size() > 0) begin
                cur       = pending_reqs.pop_front();
                have_cur  = 1'b1;
                wait_left = cur.gap;
            end
            if (have_cur && !nv) begin
                if (wait_left > 0) begin
                    wait_left--;
                end else if (!cur.drain || replies_due.size() == 0) begin
                    nv = 1'b1;
                    i_cmd   <= cur.cmd;
                    i_value <= cur.value;
                end
            end
        end
        i_in_valid <= nv;
    end

    // ---------------------------------------------------------------- reply stall
    // Random stall bursts with occasional calm stretches of no stall at all.
    always @(negedge i_clk) begin
        logic ns;
        ns = 1'b0;
        if (calm_left > 0) begin
            calm_left--;
        end else if (stall_left > 0) begin
            ns = 1'b1;
            stall_left--;
        end else if ($urandom_range(0, 499) == 0) begin
            calm_left = $urandom_range(100, 300);
        end else if ($urandom_range(0, 99) < 20) begin
            stall_left = rand_gap();
        end
        i_out_stall <= ns;
    end

    // ---------------------------------------------------------------- sequencing
    initial begin
        int k;
        stack_now.ent  = '{default: '0};
        stack_now.fill = 0;
        stack_gen      = stack_now;

        // directed: empty-stack cases, field extremes, duplicates, gap closing
        add_req(swvr_pkg::CMD_POP,    32'h0);           // pop when empty
        add_req(swvr_pkg::CMD_REMOVE, 32'h0);           // remove when empty
        add_req(CMD_NOP,              32'h0);           // unused code on empty stack
        add_req(swvr_pkg::CMD_PUSH,   32'h8000_0000);
        add_req(swvr_pkg::CMD_PUSH,   32'h7FFF_FFFF);
        add_req(swvr_pkg::CMD_PUSH,   32'h0);
        add_req(swvr_pkg::CMD_PUSH,   32'hFFFF_FFFF);
        add_req(swvr_pkg::CMD_PUSH,   32'h8000_0000);
        add_req(swvr_pkg::CMD_REMOVE, 32'h8000_0000);   // top copy goes, bottom copy stays
        add_req(swvr_pkg::CMD_REMOVE, 32'h1234_5678);   // no match
        add_req(swvr_pkg::CMD_REMOVE, 32'h7FFF_FFFF);   // middle entry, rest shifts down
        add_req(CMD_NOP,              32'hFFFF_FFFF);   // unused code with data
        add_req(swvr_pkg::CMD_POP,    32'h0);
        add_req(swvr_pkg::CMD_REMOVE, 32'h8000_0000);   // bottom entry
        add_req(swvr_pkg::CMD_POP,    32'h0);
        add_req(swvr_pkg::CMD_POP,    32'h0);           // empty again

        // random: well-formed sequences with random content, plus noise
        add_fill_seq();                         // full stack early on
        drain_next = 1'b1;                      // sender waits for all replies once
        while (real_reqs < TARGET_REQS) begin
            seq_calm = ($urandom_range(0, 9) < 3);
            k = $urandom_range(0, 19);
            if (k <= 5) begin
                repeat ($urandom_range(1, 18)) add_req(swvr_pkg::CMD_PUSH, pick_value());
            end else if (k <= 10) begin
                add_remove_seq($urandom_range(1, 8));
            end else if (k <= 13) begin
                repeat ($urandom_range(1, 10)) add_req(swvr_pkg::CMD_POP, pick_value());
            end else if (k <= 15) begin
                add_fill_seq();
            end else if (k <= 17) begin
                repeat ($urandom_range(1, 6))
                    add_req(swvr_pkg::t_cmd'($urandom_range(0, 3)), $urandom);
            end else if (k == 18) begin
                drain_next = 1'b1;
            end else begin
                while (stack_gen.fill > 0) add_req(swvr_pkg::CMD_POP, pick_value());
                add_req(swvr_pkg::CMD_POP, pick_value());
                add_req(swvr_pkg::CMD_REMOVE, pick_value());
            end
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || have_cur || replies_due.size() > 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (replies_due.size() != 0)
            report_mismatch($sformatf("%0d predicted replies never arrived",
                                      replies_due.size()));
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
